### hdl/tfr_pkg.sv
// shared types and constants for the task fifo with id removal
// no dependencies; the datapath, controller and top modules import this package
package tfr_pkg;

  // field widths fixed by the interface
  localparam int CAP_W  = 5;
  localparam int FILL_W = 5;

  // request type codes
  localparam logic [2:0] OP_ENQ    = 3'd0;
  localparam logic [2:0] OP_DEQ    = 3'd1;
  localparam logic [2:0] OP_PEEK   = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_FIND   = 3'd4;

  // result codes
  localparam logic [1:0] RC_OK        = 2'd0;
  localparam logic [1:0] RC_FULL      = 2'd1;
  localparam logic [1:0] RC_EMPTY     = 2'd2;
  localparam logic [1:0] RC_NOT_FOUND = 2'd3;

  // request transaction
  typedef struct packed {
    logic [2:0]  req_type;
    logic [2:0]  kind_in;
    logic [1:0]  prio_in;
    logic [31:0] desc_handle_in;
    logic [31:0] lookup_id;
  } req_t;

  // result transaction
  typedef struct packed {
    logic [1:0]        result_code;
    logic [31:0]       out_id;
    logic [2:0]        out_kind;
    logic [1:0]        out_prio;
    logic [31:0]       out_stamp;
    logic [31:0]       out_desc_handle;
    logic [FILL_W-1:0] fill_count;
    logic              is_empty;
  } rsp_t;

  // one stored task record
  typedef struct packed {
    logic [31:0] id;
    logic [2:0]  kind;
    logic [1:0]  prio;
    logic [31:0] stamp;
    logic [31:0] desc;
  } rec_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_SHIFT,
    ST_FINISH
  } state_t;

  // which record the result carries
  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_REC,
    SEL_ENQ
  } sel_t;

  // fill count adjustment applied with the result
  typedef enum logic [1:0] {
    ADJ_NONE,
    ADJ_INC,
    ADJ_DEC
  } adj_t;

  // how a request finishes
  typedef struct packed {
    logic [1:0] code;
    sel_t       sel;
    adj_t       adj;
  } fin_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic sweep_start;
    logic from_next;
    logic sweep_step;
    logic shift;
    logic capture;
    logic load;
    fin_t res;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       empty;
    logic       full;
    logic       hit;
    logic       sweep_done;
    logic       out_free;
  } stat_t;

endpackage

### hdl/tfr_ram.sv
// generic simple dual port ram with registered read
// no dependencies
module tfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/tfr_datapath.sv
// datapath: record store, fill and id counters, sweep pointer, result register
// depends on tfr_pkg and tfr_ram
module tfr_datapath import tfr_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  req_t             req,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  output rsp_t             rsp,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  input  cmd_t             cmd,
  output stat_t            stat
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;
  localparam int RW = $bits(rec_t);

  req_t             req_q;
  logic [CAP_W-1:0] cap;
  logic [CW-1:0]    held;
  logic [CW-1:0]    held_new;
  logic [31:0]      next_id;
  logic [31:0]      stamp_cnt;
  logic [CW-1:0]    ptr;
  logic [IW-1:0]    rd_idx;
  logic             rd_pend;
  rec_t             rec;
  rec_t             rd_rec;
  rec_t             new_rec;
  rec_t             out_rec;
  rsp_t             rsp_next;
  logic [LW-1:0]    cap_ext;
  logic [LW-1:0]    held_ext;
  logic [LW-1:0]    held_new_ext;
  logic [LW-1:0]    limit;
  logic             rd_en;
  logic             wr_en;
  logic             enq_load;
  logic [IW-1:0]    wr_addr;
  logic [RW-1:0]    wr_data;
  logic [RW-1:0]    ram_rdata;
  logic             first_mode;

  // record store
  tfr_ram #(
    .WIDTH(RW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(ptr[IW-1:0]),
    .rdata(ram_rdata)
  );

  assign rd_rec = rec_t'(ram_rdata);

  // effective capacity: zero or above depth means full depth
  assign cap_ext  = LW'(cap);
  assign held_ext = LW'(held);
  always_comb begin
    if (cap_ext == '0 || cap_ext > LW'(DEPTH)) begin
      limit = LW'(DEPTH);
    end else begin
      limit = cap_ext;
    end
  end

  // sweep reads one slot per cycle below the fill count
  assign rd_en = cmd.sweep_step && (ptr < held);

  // shift writes the pending slot one place down; enqueue writes at the tail
  assign enq_load = cmd.load && (cmd.res.sel == SEL_ENQ);
  assign wr_en    = (cmd.sweep_step && cmd.shift && rd_pend) || enq_load;
  assign wr_addr  = cmd.shift ? (rd_idx - IW'(1)) : held[IW-1:0];
  assign wr_data  = cmd.shift ? ram_rdata : RW'(new_rec);

  // dequeue and peek take the first slot read, the others match on id
  assign first_mode = (req_q.req_type == OP_DEQ) || (req_q.req_type == OP_PEEK);

  // status to controller
  assign stat.op         = req_q.req_type;
  assign stat.empty      = (held == '0);
  assign stat.full       = (held_ext >= limit);
  assign stat.hit        = rd_pend && (first_mode || rd_rec.id == req_q.lookup_id);
  assign stat.sweep_done = !rd_pend && (ptr >= held);
  assign stat.out_free   = !rsp_valid || !rsp_stall;

  // result assembly
  always_comb begin
    new_rec.id    = next_id;
    new_rec.kind  = req_q.kind_in;
    new_rec.prio  = req_q.prio_in;
    new_rec.stamp = stamp_cnt;
    new_rec.desc  = req_q.desc_handle_in;

    held_new = held;
    unique case (cmd.res.adj)
      ADJ_NONE: held_new = held;
      ADJ_INC:  held_new = held + CW'(1);
      ADJ_DEC:  held_new = held - CW'(1);
      default:  held_new = held;
    endcase
    held_new_ext = LW'(held_new);

    unique case (cmd.res.sel)
      SEL_ZERO: out_rec = '0;
      SEL_REC:  out_rec = rec;
      SEL_ENQ:  out_rec = new_rec;
      default:  out_rec = '0;
    endcase

    rsp_next.result_code     = cmd.res.code;
    rsp_next.out_id          = out_rec.id;
    rsp_next.out_kind        = out_rec.kind;
    rsp_next.out_prio        = out_rec.prio;
    rsp_next.out_stamp       = out_rec.stamp;
    rsp_next.out_desc_handle = out_rec.desc;
    rsp_next.fill_count      = held_new_ext[FILL_W-1:0];
    rsp_next.is_empty        = (held_new == '0);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= '0;
      held      <= '0;
      next_id   <= 32'd1;
      stamp_cnt <= 32'd1;
      ptr       <= '0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_data;
      end

      // sweep pointer
      if (cmd.sweep_start) begin
        ptr     <= cmd.from_next ? (CW'(rd_idx) + CW'(1)) : '0;
        rd_pend <= 1'b0;
      end else if (cmd.sweep_step) begin
        rd_pend <= rd_en;
        if (rd_en) begin
          ptr <= ptr + CW'(1);
        end
      end

      // result handoff and state update
      if (cmd.load) begin
        rsp_valid <= 1'b1;
        held      <= held_new;
        if (enq_load) begin
          next_id   <= next_id + 32'd1;
          stamp_cnt <= stamp_cnt + 32'd1;
        end
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q <= req;
    end
    if (rd_en) begin
      rd_idx <= ptr[IW-1:0];
    end
    if (cmd.capture) begin
      rec <= rd_rec;
    end
    if (cmd.load) begin
      rsp <= rsp_next;
    end
  end

endmodule

### hdl/tfr_ctrl.sv
// controller state machine sequencing dispatch, search, gap closing and result
// depends on tfr_pkg
module tfr_ctrl import tfr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;
  fin_t   fin;
  fin_t   fin_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // finish descriptor
  always_ff @(posedge clk) begin
    fin <= fin_next;
  end

  assign req_stall = (state != ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    fin_next   = fin;
    cmd        = '0;
    cmd.res    = fin;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        unique case (stat.op)
          OP_ENQ: begin
            state_next = ST_FINISH;
            if (stat.full) begin
              fin_next = '{code: RC_FULL, sel: SEL_ZERO, adj: ADJ_NONE};
            end else begin
              fin_next = '{code: RC_OK, sel: SEL_ENQ, adj: ADJ_INC};
            end
          end
          OP_DEQ, OP_PEEK, OP_REMOVE: begin
            if (stat.empty) begin
              fin_next   = '{code: RC_EMPTY, sel: SEL_ZERO, adj: ADJ_NONE};
              state_next = ST_FINISH;
            end else begin
              cmd.sweep_start = 1'b1;
              state_next      = ST_SCAN;
            end
          end
          OP_FIND: begin
            cmd.sweep_start = 1'b1;
            state_next      = ST_SCAN;
          end
          default: begin
            fin_next   = '{code: RC_OK, sel: SEL_ZERO, adj: ADJ_NONE};
            state_next = ST_FINISH;
          end
        endcase
      end

      // walk entries oldest first until a hit or the end
      ST_SCAN: begin
        if (stat.hit) begin
          cmd.capture = 1'b1;
          if (stat.op == OP_DEQ || stat.op == OP_REMOVE) begin
            cmd.sweep_start = 1'b1;
            cmd.from_next   = 1'b1;
            fin_next        = '{code: RC_OK, sel: SEL_REC, adj: ADJ_DEC};
            state_next      = ST_SHIFT;
          end else begin
            fin_next   = '{code: RC_OK, sel: SEL_REC, adj: ADJ_NONE};
            state_next = ST_FINISH;
          end
        end else if (stat.sweep_done) begin
          fin_next   = '{code: RC_NOT_FOUND, sel: SEL_ZERO, adj: ADJ_NONE};
          state_next = ST_FINISH;
        end else begin
          cmd.sweep_step = 1'b1;
        end
      end

      // move later entries down one slot to close the gap
      ST_SHIFT: begin
        cmd.sweep_step = 1'b1;
        cmd.shift      = 1'b1;
        if (stat.sweep_done) begin
          state_next = ST_FINISH;
        end
      end

      // hand the result to the output register once it is free
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/task_fifo_with_id_removal_unit.sv
// task fifo with id removal: one request at a time, one result transaction each.
// enqueue, undefined and empty results finish without a search; dequeue, peek, remove
// and find search oldest first (find also on an empty queue), and a remove or dequeue
// hit then moves the later entries down one slot.
// the next request is accepted while the result is offered; a stalled result holds back only the next result.
// synchronous reset empties the queue, sets id and stamp counters to 1, capacity to 0 (full depth).
module task_fifo_with_id_removal_unit import tfr_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // sequencing
  tfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and result path
  tfr_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .rsp      (rsp),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
